@@ src/twtlc_pkg.sv @@
package twtlc_pkg;

  typedef enum logic [1:0] {
    MODE_A    = 2'd0,
    MODE_B    = 2'd1,
    MODE_WARN = 2'd2,
    MODE_HOLD = 2'd3
  } mode_t;

  localparam int unsigned TickW = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_WEST_RED  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOUTH_RED = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_AMBER     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_WARNING   = 2'd3;

  localparam logic [TickW-1:0] WEST_RED_RST  = 7'd15;
  localparam logic [TickW-1:0] SOUTH_RED_RST = 7'd23;
  localparam logic [TickW-1:0] AMBER_RST     = 7'd3;
  localparam logic [TickW-1:0] WARNING_RST   = 7'd3;

  typedef struct packed {
    logic [TickW-1:0] west_red_ticks;
    logic [TickW-1:0] south_red_ticks;
    logic [TickW-1:0] amber_ticks;
    logic [TickW-1:0] warning_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [TickW-1:0] tick;
    logic             last_south;
    logic             warn_south;
  } state_t;

  typedef struct packed {
    logic       red_west;
    logic       amber_west;
    logic       green_west;
    logic       red_south;
    logic       amber_south;
    logic       green_south;
    logic [7:0] display_code;
    logic       display_on;
  } res_t;

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    return (v == '0) ? 7'd1 : v;
  endfunction

  // units in upper nibble, tens in lower; x*205>>11 == x/10 for x < 1029
  function automatic logic [7:0] bcd_swapped(input logic [TickW-1:0] v);
    logic [TickW-1:0] c;
    logic [14:0]      p;
    logic [3:0]       tens;
    logic [TickW-1:0] u;
    c    = (v > 7'd99) ? 7'd99 : v;
    p    = 15'(c) * 15'd205;
    tens = p[14:11];
    u    = c - 7'(tens) * 7'd10;
    return {u[3:0], tens};
  endfunction

endpackage

@@ src/twtlc_step.sv @@
module twtlc_step (
  input  twtlc_pkg::cfg_t   cfg,
  input  twtlc_pkg::state_t st_i,
  input  logic              manual_switch,
  input  logic              south_switch,
  output twtlc_pkg::state_t st_o,
  output twtlc_pkg::res_t   res_o
);

  always_comb begin
    twtlc_pkg::mode_t             m;
    logic [twtlc_pkg::TickW-1:0]  t;
    logic                         ls;
    logic                         wt;
    logic                         done;
    logic                         pa;
    logic                         amber;
    logic [twtlc_pkg::TickW-1:0]  wlen;
    logic [twtlc_pkg::TickW-1:0]  plen;
    logic [twtlc_pkg::TickW-1:0]  cnt;
    twtlc_pkg::res_t              r;

    m    = st_i.mode;
    t    = st_i.tick;
    ls   = st_i.last_south;
    wt   = st_i.warn_south;
    done = 1'b0;
    cnt  = '0;
    r    = '0;
    pa   = 1'b0;
    amber = 1'b0;
    plen = '0;
    wlen = twtlc_pkg::at_least_one(cfg.warning_ticks);

    if (m == twtlc_pkg::MODE_WARN) begin
      if (t < wlen) begin
        r.amber_west  = wt;
        r.red_south   = wt;
        r.amber_south = ~wt;
        r.red_west    = ~wt;
        r.display_on  = 1'b1;
        cnt  = wlen - t;
        t    = t + 7'd1;
        done = 1'b1;
      end else begin
        ls = wt;
        m  = twtlc_pkg::MODE_HOLD;
        t  = '0;
      end
    end

    if (!done && m == twtlc_pkg::MODE_HOLD && !manual_switch) begin
      m = twtlc_pkg::MODE_A;
      t = '0;
    end

    if (!done && m != twtlc_pkg::MODE_HOLD) begin
      plen = twtlc_pkg::at_least_one((m == twtlc_pkg::MODE_A) ? cfg.west_red_ticks
                                                               : cfg.south_red_ticks);
      if (t >= plen) begin
        m = (m == twtlc_pkg::MODE_A) ? twtlc_pkg::MODE_B : twtlc_pkg::MODE_A;
        t = '0;
      end
    end

    if (!done && manual_switch) begin
      if (south_switch != ls) begin
        m  = twtlc_pkg::MODE_WARN;
        wt = south_switch;
        r.amber_west  = wt;
        r.red_south   = wt;
        r.amber_south = ~wt;
        r.red_west    = ~wt;
        r.display_on  = 1'b1;
        cnt = wlen;
        t   = 7'd1;
      end else begin
        m = twtlc_pkg::MODE_HOLD;
        t = '0;
        r.green_south = ls;
        r.red_west    = ls;
        r.green_west  = ~ls;
        r.red_south   = ~ls;
      end
      done = 1'b1;
    end

    if (!done) begin
      pa   = (m == twtlc_pkg::MODE_A);
      plen = twtlc_pkg::at_least_one(pa ? cfg.west_red_ticks : cfg.south_red_ticks);
      amber = ({1'b0, t} + {1'b0, cfg.amber_ticks}) >= {1'b0, plen};
      ls   = pa;
      r.red_west    = pa;
      r.amber_south = pa & amber;
      r.green_south = pa & ~amber;
      r.red_south   = ~pa;
      r.amber_west  = ~pa & amber;
      r.green_west  = ~pa & ~amber;
      r.display_on  = 1'b1;
      cnt = plen - t;
      t   = t + 7'd1;
      if (t >= plen) begin
        m = pa ? twtlc_pkg::MODE_B : twtlc_pkg::MODE_A;
        t = '0;
      end
    end

    r.display_code = r.display_on ? twtlc_pkg::bcd_swapped(cnt) : 8'd0;

    st_o.mode       = m;
    st_o.tick       = t;
    st_o.last_south = ls;
    st_o.warn_south = wt;
    res_o           = r;
  end

endmodule

@@ src/two_way_traffic_light_controller_core.sv @@
// A result beat is registered and presented in the cycle after its tick beat is accepted.
// One tick per cycle while in_ready is high; the controller state and the result register
// both update on the accepting edge, and in_ready drops only while a result waits unread.
// Reset (synchronous, rst_n low): auto phase A at its first tick, west served last,
// timing registers back to 15/23/3/3, output register empty.
module two_way_traffic_light_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [twtlc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [twtlc_pkg::TickW-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_manual_switch,
  input  logic                            in_south_switch,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_red_west,
  output logic                            out_amber_west,
  output logic                            out_green_west,
  output logic                            out_red_south,
  output logic                            out_amber_south,
  output logic                            out_green_south,
  output logic [7:0]                      out_display_code,
  output logic                            out_display_on
);

  twtlc_pkg::cfg_t   cfg_r;
  twtlc_pkg::state_t state_r;
  twtlc_pkg::state_t state_nxt;
  twtlc_pkg::res_t   res_r;
  twtlc_pkg::res_t   res_nxt;
  logic              out_valid_r;
  logic              accept;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  twtlc_step u_step (
    .cfg           (cfg_r),
    .st_i          (state_r),
    .manual_switch (in_manual_switch),
    .south_switch  (in_south_switch),
    .st_o          (state_nxt),
    .res_o         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.west_red_ticks  <= twtlc_pkg::WEST_RED_RST;
      cfg_r.south_red_ticks <= twtlc_pkg::SOUTH_RED_RST;
      cfg_r.amber_ticks     <= twtlc_pkg::AMBER_RST;
      cfg_r.warning_ticks   <= twtlc_pkg::WARNING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        twtlc_pkg::CFG_WEST_RED:  cfg_r.west_red_ticks  <= cfg_data;
        twtlc_pkg::CFG_SOUTH_RED: cfg_r.south_red_ticks <= cfg_data;
        twtlc_pkg::CFG_AMBER:     cfg_r.amber_ticks     <= cfg_data;
        twtlc_pkg::CFG_WARNING:   cfg_r.warning_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= twtlc_pkg::MODE_A;
      state_r.tick       <= '0;
      state_r.last_south <= 1'b0;
      state_r.warn_south <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_west     = res_r.red_west;
  assign out_amber_west   = res_r.amber_west;
  assign out_green_west   = res_r.green_west;
  assign out_red_south    = res_r.red_south;
  assign out_amber_south  = res_r.amber_south;
  assign out_green_south  = res_r.green_south;
  assign out_display_code = res_r.display_code;
  assign out_display_on   = res_r.display_on;

endmodule
